[design/iptc_pkg.sv]
// ----------------------------------------------------------------------------
// iptc_pkg
// shared types and constants for the iptc record stream parser
// ----------------------------------------------------------------------------
package iptc_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_STREAM_LENGTH = 1'b0;   // register index, paddr[2]

    // byte codes
    localparam logic [7:0] MARKER_BYTE   = 8'h1C;
    localparam logic [7:0] RECORD_ONE    = 8'h01;
    localparam logic [7:0] RECORD_TWO    = 8'h02;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // stop reasons
    localparam logic [1:0] STOP_BUFFER_END = 2'd0;
    localparam logic [1:0] STOP_BAD_MARKER = 2'd1;
    localparam logic [1:0] STOP_SHORT_HDR  = 2'd2;
    localparam logic [1:0] STOP_BAD_LENGTH = 2'd3;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_MARKER = 3'd1,
        PH_DSET   = 3'd2,
        PH_REC    = 3'd3,
        PH_LEN    = 3'd4,
        PH_LONG   = 3'd5,
        PH_VALUE  = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_buffer;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  dataset;
        logic [7:0]  record_number;
        logic [30:0] value_length;
        logic [7:0]  value_byte;
        logic        last_value_byte;
        logic [30:0] tags_found;
        logic [1:0]  stop_reason;
        logic        found_any;
    } result_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] n;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

[design/iptc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// iptc_cfg_regs
// apb-style register file holding the buffer length
// ----------------------------------------------------------------------------
module iptc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [iptc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [30:0]                      stream_length
);

    logic [30:0] stream_length_reg;
    logic [30:0] stream_length_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        stream_length_next = stream_length_reg;
        if (wr_en && paddr[2] == iptc_pkg::REG_STREAM_LENGTH)
        begin
            stream_length_next = pwdata[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= '0;
        end
        else
        begin
            stream_length_reg <= stream_length_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == iptc_pkg::REG_STREAM_LENGTH)
        begin
            prdata = {1'b0, stream_length_reg};
        end
    end

    assign stream_length = stream_length_reg;

endmodule

[design/iptc_parse_core.sv]
// ----------------------------------------------------------------------------
// iptc_parse_core
// parser state and the single-pass per-byte step logic
// ----------------------------------------------------------------------------
module iptc_parse_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  iptc_pkg::item_t   item,
    input  logic [30:0]       stream_length,
    output iptc_pkg::push_t   push
);

    iptc_pkg::phase_t phase_reg,  phase_next,  eff_phase;
    logic [30:0]      pos_reg,    pos_next,    eff_pos;
    logic             pend_reg,   pend_next,   eff_pend;
    logic [7:0]       dset_reg,   dset_next,   eff_dset;
    logic [7:0]       rec_reg,    rec_next,    eff_rec;
    logic [31:0]      acc_reg,    acc_next,    eff_acc;
    logic [2:0]       lidx_reg,   lidx_next,   eff_lidx;
    logic [30:0]      remain_reg, remain_next, eff_remain;
    logic [30:0]      count_reg,  count_next,  eff_count;

    logic [7:0]  b;
    logic [31:0] lim;
    logic [31:0] p1, p4, p5, p6;
    logic [30:0] count_inc;
    logic [31:0] fin_len;
    logic [32:0] len_sum;
    logic        fin_bad;
    logic        do_finish;
    logic        do_stop;
    logic [1:0]  stop_code;

    function automatic iptc_pkg::result_t mk_res(
        input logic [1:0]  kind,
        input logic [7:0]  ds,
        input logic [7:0]  rc,
        input logic [30:0] vl,
        input logic [7:0]  vb,
        input logic        last,
        input logic [1:0]  reason,
        input logic [30:0] cnt
    );
        iptc_pkg::result_t r;
        r.kind            = kind;
        r.dataset         = ds;
        r.record_number   = rc;
        r.value_length    = vl;
        r.value_byte      = vb;
        r.last_value_byte = last;
        r.tags_found      = cnt;
        r.stop_reason     = reason;
        r.found_any       = (cnt != '0);
        return r;
    endfunction

    // start of buffer clears the parse before the byte is looked at
    always_comb
    begin
        if (item.first_of_buffer)
        begin
            eff_phase  = iptc_pkg::PH_SEARCH;
            eff_pos    = '0;
            eff_pend   = 1'b0;
            eff_dset   = '0;
            eff_rec    = '0;
            eff_acc    = '0;
            eff_lidx   = '0;
            eff_remain = '0;
            eff_count  = '0;
        end
        else
        begin
            eff_phase  = phase_reg;
            eff_pos    = pos_reg;
            eff_pend   = pend_reg;
            eff_dset   = dset_reg;
            eff_rec    = rec_reg;
            eff_acc    = acc_reg;
            eff_lidx   = lidx_reg;
            eff_remain = remain_reg;
            eff_count  = count_reg;
        end
    end

    assign b         = item.data_byte;
    assign lim       = {1'b0, stream_length};
    assign p1        = {1'b0, eff_pos} + 32'd1;
    assign p4        = {1'b0, eff_pos} + 32'd4;
    assign p5        = {1'b0, eff_pos} + 32'd5;
    assign p6        = {1'b0, eff_pos} + 32'd6;
    assign count_inc = eff_count + 31'd1;

    // candidate length when the length field completes on this byte
    assign fin_len = (eff_phase == iptc_pkg::PH_LONG) ? {eff_acc[23:0], b}
                                                      : {16'd0, eff_acc[7:0], b};
    assign len_sum = {1'b0, p1} + {1'b0, fin_len};
    assign fin_bad = fin_len[31] || (fin_len > lim) || (len_sum > {1'b0, lim});

    always_comb
    begin
        phase_next  = eff_phase;
        pos_next    = eff_pos;
        pend_next   = eff_pend;
        dset_next   = eff_dset;
        rec_next    = eff_rec;
        acc_next    = eff_acc;
        lidx_next   = eff_lidx;
        remain_next = eff_remain;
        count_next  = eff_count;
        push        = '0;
        do_finish   = 1'b0;
        do_stop     = 1'b0;
        stop_code   = iptc_pkg::STOP_BUFFER_END;

        if (eff_phase != iptc_pkg::PH_DONE && eff_pos < stream_length)
        begin
            pos_next = p1[30:0];
            case (eff_phase)
                iptc_pkg::PH_SEARCH:
                begin
                    if (eff_pend && (b == iptc_pkg::RECORD_ONE || b == iptc_pkg::RECORD_TWO))
                    begin
                        pend_next = 1'b0;
                        if (p4 >= lim)
                        begin
                            do_stop   = 1'b1;
                            stop_code = iptc_pkg::STOP_SHORT_HDR;
                        end
                        else
                        begin
                            dset_next  = b;
                            phase_next = iptc_pkg::PH_REC;
                        end
                    end
                    else
                    begin
                        pend_next = (b == iptc_pkg::MARKER_BYTE);
                        // a marker in the last byte has nothing to look ahead at
                        if (p1 >= lim)
                        begin
                            do_stop   = 1'b1;
                            stop_code = iptc_pkg::STOP_BUFFER_END;
                        end
                    end
                end
                iptc_pkg::PH_MARKER:
                begin
                    if (b != iptc_pkg::MARKER_BYTE)
                    begin
                        do_stop   = 1'b1;
                        stop_code = iptc_pkg::STOP_BAD_MARKER;
                    end
                    else if (p5 >= lim)
                    begin
                        do_stop   = 1'b1;
                        stop_code = iptc_pkg::STOP_SHORT_HDR;
                    end
                    else
                    begin
                        phase_next = iptc_pkg::PH_DSET;
                    end
                end
                iptc_pkg::PH_DSET:
                begin
                    dset_next  = b;
                    phase_next = iptc_pkg::PH_REC;
                end
                iptc_pkg::PH_REC:
                begin
                    rec_next   = b;
                    acc_next   = '0;
                    lidx_next  = '0;
                    phase_next = iptc_pkg::PH_LEN;
                end
                iptc_pkg::PH_LEN:
                begin
                    if (eff_lidx == 3'd0)
                    begin
                        if (b[7])
                        begin
                            if (p6 >= lim)
                            begin
                                do_stop   = 1'b1;
                                stop_code = iptc_pkg::STOP_SHORT_HDR;
                            end
                            else
                            begin
                                acc_next   = '0;
                                lidx_next  = 3'd1;
                                phase_next = iptc_pkg::PH_LONG;
                            end
                        end
                        else
                        begin
                            acc_next  = {24'd0, b};
                            lidx_next = 3'd1;
                        end
                    end
                    else
                    begin
                        do_finish = 1'b1;
                    end
                end
                iptc_pkg::PH_LONG:
                begin
                    // byte 1 of the long field is skipped, bytes 2 to 5 carry the length
                    if (eff_lidx >= 3'd2)
                    begin
                        acc_next = {eff_acc[23:0], b};
                    end
                    if (eff_lidx >= 3'd5)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        lidx_next = eff_lidx + 3'd1;
                    end
                end
                iptc_pkg::PH_VALUE:
                begin
                    if (eff_remain <= 31'd1)
                    begin
                        remain_next = '0;
                        count_next  = count_inc;
                        push.res0   = mk_res(iptc_pkg::KIND_VALUE, eff_dset, eff_rec,
                                             eff_acc[30:0], b, 1'b1,
                                             iptc_pkg::STOP_BUFFER_END, count_inc);
                        if (p1 >= lim)
                        begin
                            push.res1  = mk_res(iptc_pkg::KIND_SUMMARY, '0, '0, '0, '0, 1'b0,
                                                iptc_pkg::STOP_BUFFER_END, count_inc);
                            push.n     = 2'd2;
                            phase_next = iptc_pkg::PH_DONE;
                        end
                        else
                        begin
                            push.n     = 2'd1;
                            phase_next = iptc_pkg::PH_MARKER;
                        end
                    end
                    else
                    begin
                        remain_next = eff_remain - 31'd1;
                        push.res0   = mk_res(iptc_pkg::KIND_VALUE, eff_dset, eff_rec,
                                             eff_acc[30:0], b, 1'b0,
                                             iptc_pkg::STOP_BUFFER_END, eff_count);
                        push.n      = 2'd1;
                    end
                end
                default:
                begin
                    phase_next = eff_phase;
                end
            endcase

            // length field complete: a bad length stops the parse, else header, then value bytes or next record
            if (do_finish)
            begin
                acc_next = fin_len;
                if (fin_bad)
                begin
                    do_stop   = 1'b1;
                    stop_code = iptc_pkg::STOP_BAD_LENGTH;
                end
                else
                begin
                    push.res0 = mk_res(iptc_pkg::KIND_HEADER, eff_dset, eff_rec,
                                       fin_len[30:0], '0, 1'b0,
                                       iptc_pkg::STOP_BUFFER_END, eff_count);
                    push.n    = 2'd1;
                    if (fin_len == '0)
                    begin
                        // empty value completes the record on its header
                        count_next = count_inc;
                        if (p1 >= lim)
                        begin
                            push.res1  = mk_res(iptc_pkg::KIND_SUMMARY, '0, '0, '0, '0, 1'b0,
                                                iptc_pkg::STOP_BUFFER_END, count_inc);
                            push.n     = 2'd2;
                            phase_next = iptc_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = iptc_pkg::PH_MARKER;
                        end
                    end
                    else
                    begin
                        remain_next = fin_len[30:0];
                        phase_next  = iptc_pkg::PH_VALUE;
                    end
                end
            end

            if (do_stop)
            begin
                push.res0  = mk_res(iptc_pkg::KIND_SUMMARY, '0, '0, '0, '0, 1'b0,
                                    stop_code, eff_count);
                push.n     = 2'd1;
                phase_next = iptc_pkg::PH_DONE;
            end
        end

        if (!accept)
        begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= iptc_pkg::PH_SEARCH;
            pos_reg    <= '0;
            pend_reg   <= 1'b0;
            dset_reg   <= '0;
            rec_reg    <= '0;
            acc_reg    <= '0;
            lidx_reg   <= '0;
            remain_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            dset_reg   <= dset_next;
            rec_reg    <= rec_next;
            acc_reg    <= acc_next;
            lidx_reg   <= lidx_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
        end
    end

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !item.first_of_buffer && phase_reg == iptc_pkg::PH_DONE)
        |=> (phase_reg == iptc_pkg::PH_DONE))
        else $error("parse restarted without start of buffer");

    a_second_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (push.res1.kind == iptc_pkg::KIND_SUMMARY
                              && phase_next == iptc_pkg::PH_DONE))
        else $error("second result of a byte is not a closing summary");

endmodule

[design/iptc_result_queue.sv]
// ----------------------------------------------------------------------------
// iptc_result_queue
// four-entry result queue taking up to two results per cycle
// ----------------------------------------------------------------------------
module iptc_result_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  iptc_pkg::push_t   push,
    output logic              room,
    output logic              result_valid,
    input  logic              result_ready,
    output iptc_pkg::result_t result
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    iptc_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign pop          = result_valid & result_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.n == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.res1;
        end
    end

    // keep two free entries for a byte that closes a record at buffer end
    assign room         = (count_reg <= CNT_W'(DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (count_reg <= CNT_W'(DEPTH - 2)))
        else $error("results pushed without room");

endmodule

[design/iptc_record_stream_parser.sv]
// ----------------------------------------------------------------------------
// iptc_record_stream_parser
// byte-serial parser for iim-style tagged record streams
// ----------------------------------------------------------------------------
// the block takes one buffer byte per transaction and can accept a byte in
// every clock cycle. each byte goes through a combinational step against the
// parser state; its results (record header, value byte, closing summary) are
// written to a four-entry result queue as the byte is taken and leave it in
// order, one per cycle while result_ready is high. a byte causes at most two
// results (the final value byte or an empty record at buffer end, followed by
// the summary), so the intake holds off only while the queue has fewer than
// two free entries, which happens when the output side stalls. the buffer
// length comes from the stream_length register (byte address 0); write it
// while the parser is idle. a byte flagged first_of_buffer restarts the parse.
// ----------------------------------------------------------------------------
module iptc_record_stream_parser
(
    input  logic                             clk,
    input  logic                             rst_n,

    // byte input
    input  logic                             item_valid,
    output logic                             item_ready,
    input  iptc_pkg::item_t                  item,

    // result output
    output logic                             result_valid,
    input  logic                             result_ready,
    output iptc_pkg::result_t                result,

    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [iptc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic            accept;
    logic            room;
    logic [30:0]     stream_length;
    iptc_pkg::push_t push;

    // intake is open whenever the queue can absorb a worst-case byte
    assign item_ready = room;
    assign accept     = item_valid & item_ready;

    // buffer length register
    iptc_cfg_regs u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .stream_length (stream_length)
    );

    // per-byte parse step and parser state
    iptc_parse_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .item          (item),
        .stream_length (stream_length),
        .push          (push)
    );

    // result queue decouples output stalls from the intake
    iptc_result_queue u_queue
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .room          (room),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the iptc record stream parser
// ----------------------------------------------------------------------------
// byte buffers go in over the valid/ready intake and every result transaction
// is checked field by field against a cycle-free model of the parse kept in
// the bench. a short table of hand-picked bytes comes first: buffer end, the
// missed lookahead, a short header, bad marker, oversized length, empty
// records. random buffers follow, mostly well-formed record chains with random
// content, under a series of stream_length settings and three idling mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          ITEMS_PER_MIX = 350;
    localparam logic [7:0]  LONG_LEN_FLAG = 8'h80;  // length field in long form
    localparam logic [30:0] LENGTH_MAX    = '1;
    localparam logic [iptc_pkg::CFG_ADDR_W-1:0] LENGTH_ADDR =
        {iptc_pkg::REG_STREAM_LENGTH, 2'b00};

    // how a table row is checked
    typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_SUMMARY} row_check_t;
    typedef enum logic {ROW_LENGTH, ROW_BYTE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [30:0] value;     // register value or data byte
        logic        first;
        row_check_t  check;
        logic [1:0]  why;       // stop reason of a typed-in summary
    } stim_row_t;

    // dut ports
    logic                            clk;
    logic                            rst_n        = 1'b0;
    logic                            item_valid   = 1'b0;
    logic                            item_ready;
    iptc_pkg::item_t                 item         = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    iptc_pkg::result_t               result;
    logic                            psel         = 1'b0;
    logic                            penable      = 1'b0;
    logic                            pwrite       = 1'b0;
    logic [iptc_pkg::CFG_ADDR_W-1:0] paddr        = '0;
    logic [31:0]                     pwdata       = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // bench bookkeeping
    int          gap_pct      = 16;
    int          stall_pct    = 58;
    int          cycles       = 0;
    int          errors       = 0;
    int          checked      = 0;
    int          bytes_parsed = 0;
    int          items_sent   = 0;
    int          buffers_sent = 0;
    int          settings     = 0;

    stim_row_t          directed_rows[$];
    logic [7:0]         frame_bytes[$];
    iptc_pkg::result_t  pending_results[$];    // oldest first
    iptc_pkg::result_t  step_results[$];       // what the last byte caused
    bit                 byte_used;

    // parse model state
    logic [30:0]       cfg_length   = '0;
    iptc_pkg::phase_t  pr_phase     = iptc_pkg::PH_SEARCH;
    logic [30:0]       pr_pos       = '0;
    logic              pr_pending   = 1'b0;
    logic [7:0]        pr_dset      = '0;
    logic [7:0]        pr_rec       = '0;
    logic [31:0]       pr_len_acc   = '0;
    logic [2:0]        pr_len_idx   = '0;
    logic [30:0]       pr_remaining = '0;
    logic [30:0]       pr_tags      = '0;

    iptc_record_stream_parser dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    // hard stop if the run hangs
    initial
    begin
        wait (cycles >= LIMIT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // parse model
    // ------------------------------------------------------------------------

    // one result with the running tag count
    task automatic emit(logic [1:0] kind, logic [7:0] ds, logic [7:0] rc,
                        logic [30:0] vl, logic [7:0] vb, logic last);
        iptc_pkg::result_t r;
        r                 = '0;
        r.kind            = kind;
        r.dataset         = ds;
        r.record_number   = rc;
        r.value_length    = vl;
        r.value_byte      = vb;
        r.last_value_byte = last;
        r.tags_found      = pr_tags;
        r.found_any       = (pr_tags != '0);
        step_results.push_back(r);
    endtask

    // summary, then ignore everything until the next buffer
    task automatic halt(logic [1:0] why);
        emit(iptc_pkg::KIND_SUMMARY, '0, '0, '0, '0, 1'b0);
        step_results[step_results.size()-1].stop_reason = why;
        pr_phase = iptc_pkg::PH_DONE;
    endtask

    // length field complete, nxt is the position of the following byte
    task automatic close_length(longint unsigned nxt);
        longint unsigned len;
        longint unsigned lim;
        len = pr_len_acc;
        lim = cfg_length;
        if (pr_len_acc[31] || len > lim || nxt + len > lim)
            halt(iptc_pkg::STOP_BAD_LENGTH);
        else
        begin
            emit(iptc_pkg::KIND_HEADER, pr_dset, pr_rec, pr_len_acc[30:0], '0, 1'b0);
            if (len == 0)
            begin
                // an empty record is complete on its header
                pr_tags = pr_tags + 31'd1;
                if (nxt >= lim)
                    halt(iptc_pkg::STOP_BUFFER_END);
                else
                    pr_phase = iptc_pkg::PH_MARKER;
            end
            else
            begin
                pr_remaining = pr_len_acc[30:0];
                pr_phase     = iptc_pkg::PH_VALUE;
            end
        end
    endtask

    // advance the model by one accepted byte, results land in step_results
    task automatic parse_byte(iptc_pkg::item_t it);
        longint unsigned p;
        longint unsigned lim;
        logic [7:0]      b;
        step_results.delete();
        byte_used = 1'b0;
        b   = it.data_byte;
        lim = cfg_length;
        if (it.first_of_buffer)
        begin
            pr_phase     = iptc_pkg::PH_SEARCH;
            pr_pos       = '0;
            pr_pending   = 1'b0;
            pr_dset      = '0;
            pr_rec       = '0;
            pr_len_acc   = '0;
            pr_len_idx   = '0;
            pr_remaining = '0;
            pr_tags      = '0;
        end
        p = pr_pos;
        if (pr_phase != iptc_pkg::PH_DONE && p < lim)
        begin
            byte_used = 1'b1;
            pr_pos    = pr_pos + 31'd1;
            case (pr_phase)
                iptc_pkg::PH_SEARCH:
                begin
                    if (pr_pending && (b == iptc_pkg::RECORD_ONE ||
                                       b == iptc_pkg::RECORD_TWO))
                    begin
                        pr_pending = 1'b0;
                        if (p + 4 >= lim)
                            halt(iptc_pkg::STOP_SHORT_HDR);
                        else
                        begin
                            pr_dset  = b;
                            pr_phase = iptc_pkg::PH_REC;
                        end
                    end
                    else
                    begin
                        // a marker in the last byte has nothing to look at
                        pr_pending = (b == iptc_pkg::MARKER_BYTE);
                        if (p + 1 >= lim)
                            halt(iptc_pkg::STOP_BUFFER_END);
                    end
                end
                iptc_pkg::PH_MARKER:
                begin
                    if (b != iptc_pkg::MARKER_BYTE)
                        halt(iptc_pkg::STOP_BAD_MARKER);
                    else if (p + 5 >= lim)
                        halt(iptc_pkg::STOP_SHORT_HDR);
                    else
                        pr_phase = iptc_pkg::PH_DSET;
                end
                iptc_pkg::PH_DSET:
                begin
                    pr_dset  = b;
                    pr_phase = iptc_pkg::PH_REC;
                end
                iptc_pkg::PH_REC:
                begin
                    pr_rec     = b;
                    pr_len_acc = '0;
                    pr_len_idx = '0;
                    pr_phase   = iptc_pkg::PH_LEN;
                end
                iptc_pkg::PH_LEN:
                begin
                    if (pr_len_idx == 3'd0)
                    begin
                        if ((b & LONG_LEN_FLAG) != '0)
                        begin
                            if (p + 6 >= lim)
                                halt(iptc_pkg::STOP_SHORT_HDR);
                            else
                            begin
                                pr_len_acc = '0;
                                pr_len_idx = 3'd1;
                                pr_phase   = iptc_pkg::PH_LONG;
                            end
                        end
                        else
                        begin
                            pr_len_acc = {24'd0, b};
                            pr_len_idx = 3'd1;
                        end
                    end
                    else
                    begin
                        pr_len_acc = {16'd0, pr_len_acc[7:0], b};
                        close_length(p + 1);
                    end
                end
                iptc_pkg::PH_LONG:
                begin
                    // second byte of the long field is skipped
                    if (pr_len_idx >= 3'd2)
                        pr_len_acc = {pr_len_acc[23:0], b};
                    if (pr_len_idx >= 3'd5)
                        close_length(p + 1);
                    else
                        pr_len_idx = pr_len_idx + 3'd1;
                end
                iptc_pkg::PH_VALUE:
                begin
                    if (pr_remaining <= 31'd1)
                    begin
                        pr_remaining = '0;
                        pr_tags      = pr_tags + 31'd1;
                        emit(iptc_pkg::KIND_VALUE, pr_dset, pr_rec, pr_len_acc[30:0],
                             b, 1'b1);
                        if (p + 1 >= lim)
                            halt(iptc_pkg::STOP_BUFFER_END);
                        else
                            pr_phase = iptc_pkg::PH_MARKER;
                    end
                    else
                    begin
                        pr_remaining = pr_remaining - 31'd1;
                        emit(iptc_pkg::KIND_VALUE, pr_dset, pr_rec, pr_len_acc[30:0],
                             b, 1'b0);
                    end
                end
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // present one byte, wait for its transaction, queue what it should cause
    task automatic send_byte(iptc_pkg::item_t it, row_check_t chk, logic [1:0] why);
        iptc_pkg::result_t s;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        parse_byte(it);
        if (byte_used)
            bytes_parsed++;
        case (chk)
            CHK_PREDICT:
                foreach (step_results[i])
                    pending_results.push_back(step_results[i]);
            CHK_SUMMARY:
            begin
                s             = '0;
                s.kind        = iptc_pkg::KIND_SUMMARY;
                s.stop_reason = why;
                pending_results.push_back(s);
            end
            default: ;
        endcase
    endtask

    // hold the intake until every queued result has come out
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of stream_length while the parser is idle
    task automatic write_stream_length(logic [30:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LENGTH_ADDR;
        pwdata  <= {1'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        cfg_length  = v;
        settings++;
    endtask

    // ------------------------------------------------------------------------
    // random buffers
    // ------------------------------------------------------------------------

    // length field plus value bytes, now and then an oversized length
    task automatic add_length_field();
        logic [31:0] len;
        bit          oversized;
        oversized = ($urandom_range(0, 11) == 0);
        len       = oversized ? $urandom() : $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
        begin
            frame_bytes.push_back(LONG_LEN_FLAG | 8'($urandom_range(0, 127)));
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(len[31:24]);
            frame_bytes.push_back(len[23:16]);
        end
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        if (!oversized)
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // one buffer of exactly n bytes: mostly a record chain, sometimes noise
    task automatic make_frame(int unsigned n);
        frame_bytes.delete();
        if ($urandom_range(0, 9) != 0)
        begin
            // leading junk, maybe a marker without a record byte after it
            repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
            begin
                frame_bytes.push_back(iptc_pkg::MARKER_BYTE);
                frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            frame_bytes.push_back(iptc_pkg::MARKER_BYTE);
            frame_bytes.push_back($urandom_range(0, 1) ? iptc_pkg::RECORD_TWO
                                                       : iptc_pkg::RECORD_ONE);
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            add_length_field();
            while (frame_bytes.size() < n)
            begin
                if ($urandom_range(0, 19) == 0)
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                else
                    frame_bytes.push_back(iptc_pkg::MARKER_BYTE);
                frame_bytes.push_back(8'($urandom_range(0, 255)));
                frame_bytes.push_back(8'($urandom_range(0, 255)));
                add_length_field();
            end
        end
        while (frame_bytes.size() > n)
            void'(frame_bytes.pop_back());
        while (frame_bytes.size() < n)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // register setting sequence, extremes included
    function automatic logic [30:0] pick_length(int unsigned idx);
        case (idx % 10)
            0:       return '0;
            1:       return 31'd1;
            2:       return 31'd2;
            3:       return 31'd6;
            4:       return LENGTH_MAX;
            default: return 31'($urandom_range(3, 64));
        endcase
    endfunction

    // buffer size: the full length, short of it, or running past its end
    function automatic int unsigned pick_frame_size(logic [30:0] lim);
        if (lim == '0)
            return $urandom_range(1, 3);
        if (lim > 31'd64)
            return $urandom_range(8, 64);
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(1, lim);
        if ($urandom_range(0, 3) == 0)
            return lim + $urandom_range(1, 2);
        return lim;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic check_result(iptc_pkg::result_t want, iptc_pkg::result_t got);
        if (got.kind != want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
        end
        if (got.dataset != want.dataset)
        begin
            $error("dataset: expected %0d, got %0d", want.dataset, got.dataset);
            errors++;
        end
        if (got.record_number != want.record_number)
        begin
            $error("record_number: expected %0d, got %0d",
                   want.record_number, got.record_number);
            errors++;
        end
        if (got.value_length != want.value_length)
        begin
            $error("value_length: expected %0d, got %0d",
                   want.value_length, got.value_length);
            errors++;
        end
        if (got.value_byte != want.value_byte)
        begin
            $error("value_byte: expected %0d, got %0d", want.value_byte, got.value_byte);
            errors++;
        end
        if (got.last_value_byte != want.last_value_byte)
        begin
            $error("last_value_byte: expected %0d, got %0d",
                   want.last_value_byte, got.last_value_byte);
            errors++;
        end
        if (got.tags_found != want.tags_found)
        begin
            $error("tags_found: expected %0d, got %0d", want.tags_found, got.tags_found);
            errors++;
        end
        if (got.stop_reason != want.stop_reason)
        begin
            $error("stop_reason: expected %0d, got %0d",
                   want.stop_reason, got.stop_reason);
            errors++;
        end
        if (got.found_any != want.found_any)
        begin
            $error("found_any: expected %0d, got %0d", want.found_any, got.found_any);
            errors++;
        end
    endtask

    // output stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result monitor, every transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: kind %0d", result.kind);
                errors++;
            end
            else
                check_result(pending_results.pop_front(), result);
            checked++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int              mix_base;
        int              set_base;
        iptc_pkg::item_t it;

        // length zero: every byte ignored
        directed_rows.push_back('{ROW_LENGTH, 31'd0,  1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h1C, 1'b1, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        // marker in the last byte never matches, then bytes after the stop
        directed_rows.push_back('{ROW_LENGTH, 31'd2,  1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b1, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h1C, 1'b0, CHK_SUMMARY,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'hFF, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        // header cut short by the buffer end
        directed_rows.push_back('{ROW_LENGTH, 31'd5,  1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h1C, 1'b1, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h01, 1'b0, CHK_SUMMARY,
                                  iptc_pkg::STOP_SHORT_HDR});
        // two-byte record, empty record, then a bad marker
        directed_rows.push_back('{ROW_LENGTH, 31'd16, 1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h1C, 1'b1, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h02, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'hFF, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h02, 1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'hFF, 1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h1C, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h01, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h07, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h1D, 1'b0, CHK_PREDICT,
                                  iptc_pkg::STOP_BUFFER_END});
        // long length form with bit 31 set
        directed_rows.push_back('{ROW_BYTE,   31'h1C, 1'b1, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h01, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h05, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h80, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h80, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b0, CHK_SILENT,
                                  iptc_pkg::STOP_BUFFER_END});
        directed_rows.push_back('{ROW_BYTE,   31'h00, 1'b0, CHK_SUMMARY,
                                  iptc_pkg::STOP_BAD_LENGTH});

        // single reset at the start
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_LENGTH)
                write_stream_length(directed_rows[i].value);
            else
            begin
                it.data_byte       = directed_rows[i].value[7:0];
                it.first_of_buffer = directed_rows[i].first;
                send_byte(it, directed_rows[i].check, directed_rows[i].why);
            end
        end

        // random part: three idling mixes, several length settings each
        for (int mix = 0; mix < 3; mix++)
        begin
            case (mix)
                0:
                begin
                    gap_pct   = 16;
                    stall_pct = 58;
                end
                1:
                begin
                    gap_pct   = 58;
                    stall_pct = 16;
                end
                default:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            mix_base = items_sent;
            while (items_sent - mix_base < ITEMS_PER_MIX)
            begin
                write_stream_length(pick_length(settings));
                set_base = bytes_parsed;
                for (int k = 0; k < 25 && bytes_parsed - set_base < 80; k++)
                begin
                    make_frame(pick_frame_size(cfg_length));
                    foreach (frame_bytes[j])
                    begin
                        it.data_byte       = frame_bytes[j];
                        it.first_of_buffer = (j == 0);
                        send_byte(it, CHK_PREDICT, iptc_pkg::STOP_BUFFER_END);
                    end
                    buffers_sent++;
                    // now and then the sender waits for the output to empty
                    if ($urandom_range(0, 9) == 0)
                        drain();
                end
            end
        end

        // let everything come out, then watch for strays
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bytes sent, %0d parsed, in %0d random buffers over %0d settings",
                 items_sent, bytes_parsed, buffers_sent, settings);
        $display("%0d result transactions checked, %0d mismatches", checked, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
